[rtl/syn_scan_detector_unit_assert.svh]
// Assertion macros shared by the RTL of the SYN scan detector.
// Depends on nothing; the including module supplies clk and rst.
`ifndef SYN_SCAN_DETECTOR_UNIT_ASSERT_SVH
`define SYN_SCAN_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ssd_pkg.sv]
// Package of the SYN scan detector: table sizing, codes and payload types.
// Used by syn_scan_detector_unit and the testbench; depends on nothing.
`default_nettype none

package ssd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] SYN_MASK  = 8'h02;
  localparam logic [7:0] COUNT_MAX = 8'hFF;

  localparam logic [15:0] WINDOW_RESET    = 16'd60;
  localparam logic [7:0]  THRESHOLD_RESET = 8'd5;

  // configuration register indexes
  localparam logic [7:0] REG_WINDOW    = 8'd0;
  localparam logic [7:0] REG_THRESHOLD = 8'd1;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [7:0]  proto_num;
    logic [7:0]  tcp_flag_bits;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic       scan_alert;
    logic [7:0] syn_count_out;
    logic       table_full;
  } out_item_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  count;
    logic [31:0] last_seen;
  } entry_t;

endpackage

`default_nettype wire

[rtl/ssd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/syn_scan_detector_unit.sv]
// Top level of the SYN scan detector: source table scan and update sequencer.
// Depends on ssd_pkg, ssd_ram and syn_scan_detector_unit_assert.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | in        | in_valid / in_stall | in_data  (ssd_pkg::in_item_t)
//   out     | out       | out_valid/ out_stall| out_data (ssd_pkg::out_item_t)
//   cfg     | in        | cfg_valid/cfg_ready | cfg_index (8b), cfg_data (16b)
//
// A packet that is not a TCP SYN goes straight to the output state. A TCP SYN
// walks the table through the single RAM read port, one entry a cycle, with the
// compare on the registered read data of the entry before it: a hit stops the
// walk, and a miss is decided once the last entry in use has been compared (an
// empty table goes straight to the miss). in_stall drops only after the result
// is loaded, so a new packet is not taken before the last one is through.
// Synchronous reset empties the table at once through the fill count.
// in_stall is high from accept until the result is loaded into the output
// register; a stalled result holds there while the next packet is accepted.
`default_nettype none

module syn_scan_detector_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ssd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ssd_pkg::out_item_t      out_data,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // read entry i, compare entry i-1
  localparam logic [2:0] S_HIT   = 3'd2;  // elapsed-time check
  localparam logic [2:0] S_WRITE = 3'd3;  // count update and write-back
  localparam logic [2:0] S_MISS  = 3'd4;  // append new source or flag full
  localparam logic [2:0] S_OUT   = 3'd5;  // hand result to output register

  logic [2:0]                state, state_next;
  ssd_pkg::in_item_t         item, item_next;
  logic [ssd_pkg::CNT_W-1:0] used, used_next;        // fill count of the table
  logic [ssd_pkg::CNT_W-1:0] scan_idx, scan_idx_next;
  logic                      cmp_pending, cmp_pending_next;
  logic [ssd_pkg::IDX_W-1:0] cmp_idx, cmp_idx_next;
  logic [ssd_pkg::IDX_W-1:0] hit_idx, hit_idx_next;
  ssd_pkg::entry_t           hit_ent, hit_ent_next;
  logic                      restart, restart_next;
  ssd_pkg::out_item_t        res, res_next;
  logic                      out_valid_next;
  ssd_pkg::out_item_t        out_data_next;
  logic [15:0]               window, window_next;
  logic [7:0]                threshold, threshold_next;

  // RAM ports
  logic                      rd_en;
  logic [ssd_pkg::IDX_W-1:0] rd_addr;
  ssd_pkg::entry_t           rd_ent;
  logic                      wr_en;
  logic [ssd_pkg::IDX_W-1:0] wr_addr;
  ssd_pkg::entry_t           wr_ent;

  logic        in_accept;
  logic        is_syn;
  logic        hit_now;
  logic [31:0] elapsed;
  logic [7:0]  cnt_base;
  logic [7:0]  cnt_new;

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst && (state == S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign is_syn    = (in_data.proto_num == ssd_pkg::PROTO_TCP) &&
                     ((in_data.tcp_flag_bits & ssd_pkg::SYN_MASK) != 8'd0);

  // compare works on the read issued the cycle before (registered RAM output)
  assign hit_now = cmp_pending && (rd_ent.addr == item.src_ip);
  assign elapsed = item.now_seconds - hit_ent.last_seen;
  assign cnt_base = restart ? 8'd0 : hit_ent.count;
  assign cnt_new  = (cnt_base == ssd_pkg::COUNT_MAX) ? cnt_base : cnt_base + 8'd1;

  ssd_ram #(
    .WIDTH ($bits(ssd_pkg::entry_t)),
    .DEPTH (ssd_pkg::TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_ent)
  );

  always_comb begin
    state_next       = state;
    item_next        = item;
    used_next        = used;
    scan_idx_next    = scan_idx;
    cmp_pending_next = 1'b0;
    cmp_idx_next     = cmp_idx;
    hit_idx_next     = hit_idx;
    hit_ent_next     = hit_ent;
    restart_next     = restart;
    res_next         = res;
    out_valid_next   = out_valid && out_stall;
    out_data_next    = out_data;
    window_next      = window;
    threshold_next   = threshold;
    rd_en            = 1'b0;
    rd_addr          = scan_idx[ssd_pkg::IDX_W-1:0];
    wr_en            = 1'b0;
    wr_addr          = hit_idx;
    wr_ent           = '{addr: item.src_ip, count: cnt_new, last_seen: item.now_seconds};

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ssd_pkg::REG_WINDOW:    window_next    = cfg_data;
        ssd_pkg::REG_THRESHOLD: threshold_next = cfg_data[7:0];
        default: ;
      endcase
    end

    case (state)
      S_IDLE: begin
        if (in_accept) begin
          item_next     = in_data;
          scan_idx_next = '0;
          if (is_syn) begin
            state_next = S_SCAN;
          end else begin
            res_next   = '0;
            state_next = S_OUT;
          end
        end
      end
      S_SCAN: begin
        if (hit_now) begin
          hit_idx_next = cmp_idx;
          hit_ent_next = rd_ent;
          state_next   = S_HIT;
        end else if (scan_idx < used) begin
          rd_en            = 1'b1;
          cmp_pending_next = 1'b1;
          cmp_idx_next     = scan_idx[ssd_pkg::IDX_W-1:0];
          scan_idx_next    = scan_idx + 1'b1;
        end else if (!cmp_pending) begin
          state_next = S_MISS;
        end
      end
      S_HIT: begin
        restart_next = elapsed > {16'd0, window};
        state_next   = S_WRITE;
      end
      S_WRITE: begin
        wr_en      = 1'b1;
        res_next   = '{scan_alert: cnt_new > threshold, syn_count_out: cnt_new,
                       table_full: 1'b0};
        state_next = S_OUT;
      end
      S_MISS: begin
        if (used < ssd_pkg::CNT_W'(ssd_pkg::TABLE_ENTRIES)) begin
          wr_en     = 1'b1;
          wr_addr   = used[ssd_pkg::IDX_W-1:0];
          wr_ent    = '{addr: item.src_ip, count: 8'd1, last_seen: item.now_seconds};
          used_next = used + 1'b1;
          res_next  = '{scan_alert: 8'd1 > threshold, syn_count_out: 8'd1,
                        table_full: 1'b0};
        end else begin
          res_next  = '{scan_alert: 1'b0, syn_count_out: 8'd0, table_full: 1'b1};
        end
        state_next = S_OUT;
      end
      S_OUT: begin
        // load once the output register is empty or being drained
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_data_next  = res;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used        <= '0;
      cmp_pending <= 1'b0;
      out_valid   <= 1'b0;
      window      <= ssd_pkg::WINDOW_RESET;
      threshold   <= ssd_pkg::THRESHOLD_RESET;
    end else begin
      state       <= state_next;
      used        <= used_next;
      cmp_pending <= cmp_pending_next;
      out_valid   <= out_valid_next;
      window      <= window_next;
      threshold   <= threshold_next;
    end
    item     <= item_next;
    scan_idx <= scan_idx_next;
    cmp_idx  <= cmp_idx_next;
    hit_idx  <= hit_idx_next;
    hit_ent  <= hit_ent_next;
    restart  <= restart_next;
    res      <= res_next;
    out_data <= out_data_next;
  end

`include "syn_scan_detector_unit_assert.svh"

  `SSD_ASSERT_NOW(a_used_bound, 1'b1, used <= ssd_pkg::CNT_W'(ssd_pkg::TABLE_ENTRIES), "fill count beyond table size")
  `SSD_ASSERT_NEXT(a_used_step, 1'b1, (used == $past(used)) || (used == $past(used) + 1'b1), "fill count moved by more than one")
  `SSD_ASSERT_NOW(a_busy_stalls, state != S_IDLE, in_stall, "input not stalled while a packet is in work")
  `SSD_ASSERT_NOW(a_full_no_count, out_valid && out_data.table_full, !out_data.scan_alert && (out_data.syn_count_out == 8'd0), "dropped source reported with a count")

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for syn_scan_detector_unit: directed and random packet
// traffic, a table-tracking scoreboard and randomized valid/stall pressure.
// Depends on ssd_pkg and the RTL of syn_scan_detector_unit.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ssd_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;  // quiet cycles before the run is declared hung
  localparam int TAIL_CYCLES    = 80;    // settling time after the last verdict is in
  localparam int LONG_HOLD      = 400;   // receiver hold-off used to back up the input
  localparam logic [7:0] REG_UNUSED = 8'hFF;  // index past the register list, ignored

  // Scoreboard: mirrors the source table and the two registers, and keeps the
  // verdicts owed for packets the block has accepted, oldest first.
  class verdict_scoreboard;
    logic [15:0] window;
    logic [7:0]  threshold;
    logic [31:0] src_addr  [TABLE_ENTRIES];
    logic [7:0]  src_count [TABLE_ENTRIES];
    logic [31:0] src_seen  [TABLE_ENTRIES];
    bit          src_valid [TABLE_ENTRIES];
    int unsigned used_entries;
    out_item_t   expected_verdicts[$];
    int errors, packets, verdicts, writes, alerts, drops, saturated;

    function new();
      window       = WINDOW_RESET;
      threshold    = THRESHOLD_RESET;
      used_entries = 0;
      foreach (src_valid[i]) src_valid[i] = 1'b0;
    endfunction

    function void apply_register(logic [7:0] index, logic [15:0] value);
      writes++;
      if (index == REG_WINDOW) window = value;
      else if (index == REG_THRESHOLD) threshold = value[7:0];
    endfunction

    // Table update and verdict for one accepted packet.
    function out_item_t predict_verdict(in_item_t p);
      out_item_t   v;
      bit          hit;
      logic [31:0] elapsed;
      int unsigned cnt;
      v   = '0;
      hit = 1'b0;
      cnt = 0;
      if (p.proto_num == PROTO_TCP && (p.tcp_flag_bits & SYN_MASK) != 0) begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!hit && src_valid[i] && src_addr[i] == p.src_ip) begin
            elapsed = p.now_seconds - src_seen[i];
            cnt = (elapsed > window) ? 0 : src_count[i];
            if (cnt < COUNT_MAX) cnt++;
            src_count[i] = cnt;
            src_seen[i]  = p.now_seconds;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          if (used_entries < TABLE_ENTRIES) begin
            src_addr[used_entries]  = p.src_ip;
            src_count[used_entries] = 8'd1;
            src_seen[used_entries]  = p.now_seconds;
            src_valid[used_entries] = 1'b1;
            used_entries++;
            cnt = 1;
          end else begin
            v.table_full = 1'b1;
          end
        end
        if (!v.table_full && cnt > threshold) v.scan_alert = 1'b1;
        v.syn_count_out = cnt;
      end
      return v;
    endfunction

    function void note_packet(in_item_t p);
      packets++;
      expected_verdicts.insert(expected_verdicts.size(), predict_verdict(p));
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    task report_mismatch(string what);
      $display("%0t ns: mismatch on verdict %0d: %s", $time, verdicts, what);
      errors++;
    endtask

    task check_verdict(out_item_t got);
      out_item_t want;
      verdicts++;
      if (got.scan_alert) alerts++;
      if (got.table_full) drops++;
      if (got.syn_count_out == COUNT_MAX) saturated++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict arrived with no packet pending");
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.scan_alert !== want.scan_alert)
        report_mismatch($sformatf("scan_alert %b, expected %b", got.scan_alert,
                                  want.scan_alert));
      if (got.syn_count_out !== want.syn_count_out)
        report_mismatch($sformatf("syn_count_out %0d, expected %0d", got.syn_count_out,
                                  want.syn_count_out));
      if (got.table_full !== want.table_full)
        report_mismatch($sformatf("table_full %b, expected %b", got.table_full,
                                  want.table_full));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  verdict_scoreboard sb;

  // Idling mix and pressure knobs set by the main sequence, plus the hold and quiet-cycle counters.
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_request   = 0;
  int          hold_left      = 0;
  int          quiet_cycles   = 0;

  // Packet timestamp generator and the source address pool.
  logic [31:0] stamp = '0;
  int unsigned stamp_step = 10;
  logic [31:0] pool[$];

  syn_scan_detector_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Receiver: random stall at the current rate, or a long hold-off when one
  // is requested. The hold is counted down here, not in the main sequence.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Monitor: every transaction on the three channels is seen at the rising
  // edge, where inputs driven on the falling edge are stable.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_packet(in_data);
      if (out_valid && !out_stall) sb.check_verdict(out_data);
      if (cfg_valid && cfg_ready) sb.apply_register(cfg_index, cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: too long without any transaction means the block is hung.
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog expired after %0d quiet cycles", WATCHDOG_LIMIT);
    $display("syn_scan_detector_unit verification failed");
    $finish;
  end

  function automatic in_item_t make_packet(logic [31:0] ip, logic [7:0] proto,
                                           logic [7:0] flags, logic [31:0] now);
    in_item_t p;
    p.src_ip        = ip;
    p.proto_num     = proto;
    p.tcp_flag_bits = flags;
    p.now_seconds   = now;
    return p;
  endfunction

  // Mostly small forward steps; now and then a jump anywhere in the 32-bit
  // range so that wrapped elapsed times show up.
  function automatic logic [31:0] next_stamp();
    if ($urandom_range(0, 99) < 5) stamp = $urandom;
    else stamp = stamp + $urandom_range(0, stamp_step);
    return stamp;
  endfunction

  // Mostly well-formed SYNs from a small hot set of sources, the rest noise:
  // other protocols, TCP without SYN, and fresh sources.
  function automatic in_item_t random_packet(int new_pct);
    in_item_t p;
    int       r;
    r = $urandom_range(0, 99);
    if (r < new_pct) begin
      p.src_ip = $urandom;
      pool.insert(pool.size(), p.src_ip);
    end else if ($urandom_range(0, 1)) begin
      p.src_ip = pool[$urandom_range(0, 2)];
    end else begin
      p.src_ip = pool[$urandom_range(0, pool.size() - 1)];
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      p.proto_num     = $urandom;
      p.tcp_flag_bits = $urandom;
    end else if (r < 20) begin
      p.proto_num     = PROTO_TCP;
      p.tcp_flag_bits = $urandom & ~SYN_MASK;
    end else begin
      p.proto_num     = PROTO_TCP;
      p.tcp_flag_bits = $urandom | SYN_MASK;
    end
    p.now_seconds = next_stamp();
    return p;
  endfunction

  // Offers one packet, with a random idle gap first, and returns on the
  // falling edge after it was taken. Valid stays high for a follow-on packet.
  task automatic send_packet(in_item_t p);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Register write; the caller drops cfg_valid after the last one.
  task automatic write_cfg(logic [7:0] index, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Sender pauses until every verdict is in, then lets the block settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic start_phase(logic [15:0] window, logic [15:0] threshold, int sidle,
                             int rstall, int unsigned step);
    drain_results();
    write_cfg(REG_WINDOW, window);
    write_cfg(REG_THRESHOLD, threshold);
    cfg_valid      <= 1'b0;
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    stamp_step     = step;
  endtask

  task automatic run_random(int n, int new_pct);
    repeat (n) send_packet(random_packet(new_pct));
  endtask

  initial begin
    logic [31:0] hot_ip;
    sb = new();
    repeat (16) pool.insert(pool.size(), $urandom);

    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings (window 60, threshold 5).
    send_packet(make_packet(32'h0A00_0001, 8'd17, SYN_MASK, 32'd100));  // not TCP
    send_packet(make_packet(32'h0A00_0001, PROTO_TCP, 8'hFD, 32'd100)); // TCP, no SYN
    send_packet(make_packet(32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'd100));     // not TCP
    send_packet(make_packet(32'h0000_0000, PROTO_TCP, SYN_MASK, 32'd0)); // new source
    send_packet(make_packet(32'hFFFF_FFFF, PROTO_TCP, 8'hFF, 32'hFFFF_FFF0));
    // elapsed exactly the window across the wrap: keeps counting
    send_packet(make_packet(32'hFFFF_FFFF, PROTO_TCP, 8'hFF, 32'h0000_002C));
    // one past the window: count restarts
    send_packet(make_packet(32'hFFFF_FFFF, PROTO_TCP, 8'hFF, 32'h0000_0069));
    // climb past the threshold
    for (int i = 1; i <= 5; i++)
      send_packet(make_packet(32'hFFFF_FFFF, PROTO_TCP, SYN_MASK, 32'h0000_0069 + i));
    send_packet(make_packet(32'h0000_0000, PROTO_TCP, SYN_MASK, 32'd61));

    // Threshold 0 (upper data bits dropped), window 0, and an unused index.
    drain_results();
    write_cfg(REG_THRESHOLD, 16'hFF00);
    write_cfg(REG_WINDOW, 16'h0000);
    write_cfg(REG_UNUSED, 16'h1234);
    cfg_valid <= 1'b0;
    send_packet(make_packet(32'h8000_0000, PROTO_TCP, SYN_MASK, 32'd500)); // alert on first
    send_packet(make_packet(32'h8000_0000, PROTO_TCP, SYN_MASK, 32'd500)); // zero elapsed
    send_packet(make_packet(32'h8000_0000, PROTO_TCP, SYN_MASK, 32'd501)); // restart
    send_packet(make_packet(32'h0A00_0001, PROTO_TCP, 8'h12, 32'd0));      // SYN+ACK

    // One source hammered inside the widest window until its count pins;
    // timestamps move forward so the count never restarts.
    start_phase(16'hFFFF, 16'd200, 0, 0, 100);
    hot_ip = $urandom;
    for (int i = 0; i < 262; i++)
      send_packet(make_packet(hot_ip, PROTO_TCP, $urandom | SYN_MASK,
                              stamp + 32'(i * 100)));

    // Random traffic under each idling mix and several settings.
    start_phase(16'd30, 16'd3, 75, 0, 12);
    run_random(60, 10);
    start_phase(16'd1000, 16'd10, 0, 75, 300);
    run_random(60, 10);

    // Long receiver hold-off while packets keep coming: the output register
    // and the input side back up.
    start_phase(WINDOW_RESET, THRESHOLD_RESET, 8, 8, 25);
    hold_request = LONG_HOLD;
    run_random(60, 10);

    // Fill the table, then keep offering known and fresh sources.
    start_phase(16'd5, 16'd255, 0, 0, 3);
    while (sb.used_entries < TABLE_ENTRIES)
      send_packet(make_packet($urandom, PROTO_TCP, $urandom | SYN_MASK, next_stamp()));
    start_phase(16'd5, 16'd1, 0, 75, 3);
    run_random(60, 30);

    drain_results();
    $display("run covered %0d packets, %0d verdicts, %0d register writes",
             sb.packets, sb.verdicts, sb.writes);
    $display("seen %0d alerts, %0d table-full drops, %0d pinned counts, %0d mismatches",
             sb.alerts, sb.drops, sb.saturated, sb.errors);
    if (sb.errors == 0)
      $display("syn_scan_detector_unit verification clean");
    else
      $display("syn_scan_detector_unit verification failed");
    $finish;
  end

endmodule
